[hdl/slg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slg_pkg
// Types and fixed constants that the shuffled Lehmer generator modules share.
// ----------------------------------------------------------------------------
package slg_pkg;

	localparam int VALUE_W      = 31;
	localparam int PROD_W       = 46;
	localparam int MULT_W       = 15;
	localparam int WARMUP_STEPS = 8;

	localparam logic [MULT_W-1:0]  LEHMER_MULT = 15'd16807;
	localparam logic [VALUE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] SEED_RESET  = 31'd5;

	// Commands from the sequencer to the datapath, all single-cycle strobes.
	typedef struct packed {
		logic load_seed;  // load the generator from the seed register
		logic mul;        // register 16807 * state
		logic red;        // fold the product and update the state
		logic fill_wr;    // write the folded value into the table
		logic fill_last;  // last fill: held output takes the folded value
		logic slot_load;  // register the table slot picked by the held output
		logic rd_en;      // read the table entry at the slot
		logic xchg;       // swap: write state to slot, take entry as result
	} ctrl_cmd_t;

endpackage

[hdl/slg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module slg_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/slg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slg_ctrl
// Sequencer: handshakes, table initialization, draw steps and the output valid.
// ----------------------------------------------------------------------------
module slg_ctrl #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_valid,
	output logic                           s_ready,
	input  logic                           reseed,
	output logic                           m_valid,
	input  logic                           m_ready,
	input  logic                           held_zero,
	output slg_pkg::ctrl_cmd_t             cmd,
	output logic [$clog2(TABLE_DEPTH)-1:0] fill_addr
);
	import slg_pkg::*;

	localparam int AW       = $clog2(TABLE_DEPTH);
	localparam int STEPS    = WARMUP_STEPS + TABLE_DEPTH;
	localparam int CW       = $clog2(STEPS);
	localparam logic [CW-1:0] CNT_WARM = CW'(WARMUP_STEPS);
	localparam logic [CW-1:0] CNT_LAST = CW'(STEPS - 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_RED  = 6'b001000,
		ST_READ = 6'b010000,
		ST_XCHG = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          init_q, init_d;
	logic          out_valid_q;
	logic          out_free;

	assign out_free  = !out_valid_q || m_ready;
	assign m_valid   = out_valid_q;
	assign s_ready   = (state_q == ST_IDLE);
	assign fill_addr = AW'(CNT_LAST - cnt_q);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		init_d  = init_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					state_d = (reseed || held_zero) ? ST_LOAD : ST_MUL;
				end
			end
			ST_LOAD: begin
				cmd.load_seed = 1'b1;
				cnt_d         = '0;
				init_d        = 1'b1;
				state_d       = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_RED;
			end
			ST_RED: begin
				cmd.red = 1'b1;
				if (init_q) begin
					// Warm-up steps first, then the table fills from the top entry down.
					cmd.fill_wr = (cnt_q >= CNT_WARM);
					state_d     = ST_MUL;
					if (cnt_q == CNT_LAST) begin
						cmd.fill_last = 1'b1;
						init_d        = 1'b0;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end else begin
					cmd.slot_load = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_XCHG;
			end
			ST_XCHG: begin
				if (out_free) begin
					cmd.xchg = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			init_q  <= init_d;
			if (cmd.xchg) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/slg_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slg_dpath
// Datapath: seed register, Lehmer step, slot select, shuffle table, result.
// ----------------------------------------------------------------------------
module slg_dpath #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [slg_pkg::VALUE_W-1:0]    cfg_wr_data,
	input  slg_pkg::ctrl_cmd_t             cmd,
	input  logic [$clog2(TABLE_DEPTH)-1:0] fill_addr,
	output logic                           held_zero,
	output logic [slg_pkg::VALUE_W-1:0]    random_value
);
	import slg_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [31:0] SLOT_DIV = 32'(1 + (2147483646 / TABLE_DEPTH));
	localparam logic [AW:0] DEPTH_C  = (AW + 1)'(TABLE_DEPTH);

	logic [VALUE_W-1:0] seed_q;
	logic [VALUE_W-1:0] gen_q;
	logic [VALUE_W-1:0] held_q;
	logic [AW-1:0]      slot_q;
	logic [PROD_W-1:0]  prod_s1;
	logic [VALUE_W-1:0] result_q;

	logic [VALUE_W-1:0] seed_eff;
	logic [31:0]        fold_sum;
	logic [VALUE_W-1:0] gen_next;
	logic [AW-1:0]      slot_idx;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_rdata;

	// The slot is the largest k whose threshold k * SLOT_DIV the value reaches.
	// The thresholds are constants, so this is a row of parallel compares.
	function automatic logic [AW-1:0] slot_of(input logic [VALUE_W-1:0] v);
		logic [AW-1:0] s;
		s = '0;
		for (int k = 1; k < TABLE_DEPTH; k++) begin
			if ({1'b0, v} >= SLOT_DIV * 32'(k)) begin
				s = AW'(k);
			end
		end
		return s;
	endfunction

	// A seed of zero, or one equal to the modulus, would lock the generator.
	assign seed_eff = (seed_q == '0 || seed_q == LEHMER_MOD) ? VALUE_W'(1) : seed_q;

	// Mersenne modulus: fold the high bits back onto the low bits, then one correction.
	assign fold_sum = 32'(prod_s1[VALUE_W-1:0]) + 32'(prod_s1[PROD_W-1:VALUE_W]);
	assign gen_next = (fold_sum >= 32'(LEHMER_MOD)) ?
		VALUE_W'(fold_sum - 32'(LEHMER_MOD)) : fold_sum[VALUE_W-1:0];

	assign slot_idx = ({1'b0, slot_q} >= DEPTH_C) ? '0 : slot_q;

	assign ram_we    = cmd.fill_wr || cmd.xchg;
	assign ram_waddr = cmd.xchg ? slot_idx : fill_addr;

	assign held_zero    = (held_q == '0);
	assign random_value = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			gen_q  <= '0;
			held_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (cmd.load_seed) begin
				gen_q <= seed_eff;
			end else if (cmd.red) begin
				gen_q <= gen_next;
			end
			if (cmd.fill_last) begin
				held_q <= gen_next;
			end else if (cmd.xchg) begin
				held_q <= ram_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(LEHMER_MULT) * PROD_W'(gen_q);
		end
		if (cmd.slot_load) begin
			slot_q <= slot_of(held_q);
		end
		if (cmd.xchg) begin
			result_q <= ram_rdata;
		end
	end

	slg_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (gen_q & {VALUE_W{cmd.xchg}} | gen_next & {VALUE_W{!cmd.xchg}}),
		.re    (cmd.rd_en),
		.raddr (slot_idx),
		.rdata (ram_rdata)
	);

endmodule

[hdl/shuffled_lehmer_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_lehmer_generator
// Minimal standard Lehmer generator feeding a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Usage:
// Each word accepted on the s_axis channel requests one 31-bit random value,
// delivered as one word on the m_axis channel. Bit 0 of s_axis_tdata asks
// for the shuffle table to be rebuilt from the seed register before the draw.
// The seed register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// A plain draw runs the Lehmer step (multiply, then fold), during which the
// table slot is also picked, then one table read and one exchange; a new
// word is taken only once the draw has returned to idle.
// An initializing draw (reseed, or the first draw after reset) adds the
// seed load, the warm-up steps and the table fill ahead of the plain draw.
// Reset clears the generator and marks the table as empty; the seed
// returns to 5. The result sits in an output register, so a new word is
// accepted while it waits; a draw that finishes while the receiver stalls
// holds in its final step until the output register is free.
// ----------------------------------------------------------------------------
module shuffled_lehmer_generator #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [slg_pkg::VALUE_W-1:0] cfg_wr_data,   // seed_value
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [0] reseed, [7:1] zero
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata   // [30:0] random_value, [31] zero
);
	import slg_pkg::*;

	ctrl_cmd_t                    cmd;
	logic [$clog2(TABLE_DEPTH)-1:0] fill_addr;
	logic                         held_zero;
	logic [VALUE_W-1:0]           random_value;

	assign m_axis_tdata = {1'b0, random_value};

	slg_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.reseed    (s_axis_tdata[0]),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.held_zero (held_zero),
		.cmd       (cmd),
		.fill_addr (fill_addr)
	);

	slg_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.fill_addr    (fill_addr),
		.held_zero    (held_zero),
		.random_value (random_value)
	);

endmodule

[hdl/slg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slg_checker
// Port-level checks for the shuffled Lehmer generator, bound to the top level.
// ----------------------------------------------------------------------------
module slg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// A stalled result word keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// Every result is a nonzero residue below the modulus.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31] == 1'b0 && m_axis_tdata[30:0] != 31'h7FFF_FFFF
			&& m_axis_tdata[30:0] != 31'd0)
		else $error("result outside the generator range");

	// Only one request is in flight: the input closes right after an acceptance.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word accepted while a draw is running");

	// A draw steps through its multiply, fold, read and exchange states, so a result never appears right after acceptance.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared one cycle after acceptance");

endmodule

bind shuffled_lehmer_generator slg_checker u_slg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[verif/lehmer_draw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lehmer_draw_checker
// Watches the seed port and both stream channels of the shuffled Lehmer
// generator. It keeps its own copy of the generator, the held output and the
// shuffle table, predicts the value of every accepted request word, and
// compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module lehmer_draw_checker #(
	parameter int DEPTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [slg_pkg::VALUE_W-1:0] cfg_wr_data,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,   // [0] reseed, [7:1] zero
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [31:0]                 m_axis_tdata,   // [30:0] random_value, [31] zero
	output int                          fail_count,
	output int                          pending_count
);
	import slg_pkg::*;

	localparam longint unsigned MODULUS  = longint'(LEHMER_MOD);
	localparam longint unsigned SLOT_DIV = 1 + (MODULUS - 1) / DEPTH;

	logic [VALUE_W-1:0] seed_reg;
	logic [VALUE_W-1:0] lehmer_state;
	logic [VALUE_W-1:0] held_value;
	logic [VALUE_W-1:0] shuffle_table [DEPTH];
	logic [VALUE_W-1:0] expected_values [$];
	int                 mismatches;

	function automatic logic [VALUE_W-1:0] next_lehmer(input logic [VALUE_W-1:0] x);
		longint unsigned prod;
		prod = longint'(LEHMER_MULT) * (longint'(x) % MODULUS);
		return VALUE_W'(prod % MODULUS);
	endfunction

	// The seed is reduced first, so a seed equal to the modulus also becomes one.
	task automatic rebuild_table();
		logic [VALUE_W-1:0] start;
		start = VALUE_W'(longint'(seed_reg) % MODULUS);
		if (start == '0) begin
			start = 1;
		end
		lehmer_state = start;
		for (int i = 0; i < WARMUP_STEPS; i++) begin
			lehmer_state = next_lehmer(lehmer_state);
		end
		for (int i = DEPTH - 1; i >= 0; i--) begin
			lehmer_state = next_lehmer(lehmer_state);
			shuffle_table[i] = lehmer_state;
		end
		held_value = shuffle_table[0];
	endtask

	task automatic predict_draw(input logic reseed, output logic [VALUE_W-1:0] value);
		longint unsigned slot;
		if (reseed || held_value == '0) begin
			rebuild_table();
		end
		lehmer_state = next_lehmer(lehmer_state);
		slot = longint'(held_value) / SLOT_DIV;
		if (slot >= DEPTH) begin
			slot = 0;
		end
		held_value = shuffle_table[slot];
		shuffle_table[slot] = lehmer_state;
		value = held_value;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [VALUE_W-1:0] want;
		if (!arst_n) begin
			seed_reg     = SEED_RESET;
			lehmer_state = '0;
			held_value   = '0;
			for (int i = 0; i < DEPTH; i++) begin
				shuffle_table[i] = '0;
			end
			expected_values.delete();
			mismatches    = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_wr_en) begin
				seed_reg = cfg_wr_data;
			end
			// Results are retired before new requests are predicted, so a spurious
			// word can never match a prediction made at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_values.size() == 0) begin
					mismatches++;
					$error("random_value: no word expected, got %0d", m_axis_tdata[VALUE_W-1:0]);
				end else begin
					want = expected_values.pop_front();
					if (m_axis_tdata[VALUE_W-1:0] !== want) begin
						mismatches++;
						$error("random_value: expected %0d, got %0d", want,
							m_axis_tdata[VALUE_W-1:0]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_draw(s_axis_tdata[0], want);
				expected_values.push_back(want);
			end
			fail_count    <= mismatches;
			pending_count <= expected_values.size();
		end
	end

endmodule

[verif/shuffled_lehmer_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_lehmer_generator_tb
// Drives draw requests and seed writes into the shuffled Lehmer generator.
// A short directed part covers the reset seed, seed zero, a seed equal to
// the modulus, the largest seed and back-to-back reseeds; random blocks then
// follow under three idle patterns on the two channels. A separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module shuffled_lehmer_generator_tb;
	import slg_pkg::*;

	localparam int DEPTH       = 32;
	localparam int BLOCK_WORDS = 150;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 200;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               cfg_wr_en     = 1'b0;
	logic [VALUE_W-1:0] cfg_wr_data   = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata  = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [31:0]        m_axis_tdata;

	int fail_count;
	int pending_count;
	int send_idle = 9;
	int recv_idle = 50;
	int cycle_count = 0;

	shuffled_lehmer_generator #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	lehmer_draw_checker #(
		.DEPTH(DEPTH)
	) draw_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Returns at the edge where the word is taken; tvalid stays high for a
	// following word unless the sender chooses to idle first.
	task automatic request_draw(input logic reseed);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, reseed};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// The pending count is registered, so the task first lets it take in the
	// word taken last, then waits for it to reach zero.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_seed(input logic [VALUE_W-1:0] seed);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= seed;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] pick_seed();
		case ($urandom_range(4))
			0:       return '0;
			1:       return 31'd1;
			2:       return 31'h7FFF_FFFE;
			3:       return LEHMER_MOD;
			default: return VALUE_W'($urandom_range(32'd2147483646, 0));
		endcase
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first draw after reset builds the table from the reset seed.
		repeat (3) request_draw(1'b0);
		request_draw(1'b1);
		request_draw(1'b0);

		settle();
		write_seed('0);
		request_draw(1'b1);
		repeat (2) request_draw(1'b0);

		// A seed equal to the modulus reduces to zero and then to one.
		settle();
		write_seed(LEHMER_MOD);
		request_draw(1'b1);
		request_draw(1'b0);

		settle();
		write_seed(31'h7FFF_FFFE);
		repeat (2) request_draw(1'b1);
		repeat (2) request_draw(1'b0);

		// A new seed has no effect until the next reseed word.
		settle();
		write_seed(31'd1);
		request_draw(1'b0);
		request_draw(1'b1);
		repeat (3) request_draw(1'b0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 9;
					recv_idle = 50;
				end
				1: begin
					send_idle = 50;
					recv_idle = 9;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				settle();
				write_seed(pick_seed());
				for (int i = 0; i < BLOCK_WORDS; i++) begin
					request_draw($urandom_range(99) < 6);
				end
			end
		end

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/slg_pkg.sv
hdl/slg_ram.sv
hdl/slg_ctrl.sv
hdl/slg_dpath.sv
hdl/shuffled_lehmer_generator.sv
hdl/slg_checker.sv
verif/lehmer_draw_checker.sv
verif/shuffled_lehmer_generator_tb.sv
